FILE: design/rmcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmcrc_pkg;

    localparam int HEAD_BYTES_DEF = 8;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [7:0]  TARGET_MASK = 8'hFC;

    typedef enum logic [1:0] {
        RELOC_NONE     = 2'd0,
        RELOC_TARGET26 = 2'd1,
        RELOC_HILO16   = 2'd2
    } t_reloc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_CRC = 1'b0,
        CFG_FULL_CRC = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_mid_item;

    typedef struct packed {
        logic [31:0] head_crc;
        logic [31:0] full_crc;
    } t_res_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/rmcrc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcrc_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_wr, w_do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + CW'(1);
        end else if (w_do_rd && !w_do_wr) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: design/rmcrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcrc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_code_byte,
    input  wire logic [1:0]   i_reloc_kind,
    input  wire logic         i_last_byte,
    output rmcrc_pkg::t_mid_item o_item
);

    import rmcrc_pkg::*;

    logic [1:0] r_lane, n_lane;
    logic [7:0] w_masked;

    // mask relocated fields by byte lane
    always_comb begin
        case (t_reloc'(i_reloc_kind))
            RELOC_TARGET26: w_masked = (r_lane == 2'd0) ? (i_code_byte & TARGET_MASK) : 8'h00;
            RELOC_HILO16:   w_masked = r_lane[1] ? 8'h00 : i_code_byte;
            default:        w_masked = i_code_byte;
        endcase
    end

    always_comb begin
        n_lane = r_lane;
        if (i_accept) begin
            n_lane = i_last_byte ? 2'd0 : r_lane + 2'd1;
        end
    end

    assign o_item.data = w_masked;
    assign o_item.last = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= 2'd0;
        end else begin
            r_lane <= n_lane;
        end
    end

endmodule

`default_nettype wire

FILE: design/rmcrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rmcrc_back #(
    parameter int HEAD_BYTES = rmcrc_pkg::HEAD_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_avail,
    input  wire rmcrc_pkg::t_mid_item i_item,
    output logic                      o_take,
    input  wire logic                 i_res_full,
    output logic                      o_res_push,
    output rmcrc_pkg::t_res_item      o_res
);

    import rmcrc_pkg::*;

    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_head, n_head;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]      w_crc_upd;
    logic [CNT_W-1:0] w_cnt_upd;
    logic [31:0]      w_head_upd;

    assign o_take     = i_avail && (!i_item.last || !i_res_full);
    assign o_res_push = o_take && i_item.last;
    assign w_crc_upd  = crc_byte(r_crc, i_item.data);

    always_comb begin
        w_cnt_upd  = r_cnt;
        w_head_upd = r_head;
        if (r_cnt < CNT_W'(HEAD_BYTES)) begin
            w_cnt_upd = r_cnt + CNT_W'(1);
            if (w_cnt_upd == CNT_W'(HEAD_BYTES)) begin
                w_head_upd = ~w_crc_upd;
            end
        end
    end

    assign o_res.full_crc = ~w_crc_upd;
    assign o_res.head_crc = (w_cnt_upd >= CNT_W'(HEAD_BYTES)) ? w_head_upd : ~w_crc_upd;

    always_comb begin
        n_crc  = r_crc;
        n_head = r_head;
        n_cnt  = r_cnt;
        if (o_take) begin
            if (i_item.last) begin
                n_crc  = CRC_INIT;
                n_head = '0;
                n_cnt  = '0;
            end else begin
                n_crc  = w_crc_upd;
                n_head = w_head_upd;
                n_cnt  = w_cnt_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_INIT;
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_crc  <= n_crc;
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HEAD_BYTES))
        else $error("head count past limit");

    a_head_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt < CNT_W'(HEAD_BYTES)) |-> (r_head == '0))
        else $error("head crc set before head complete");

    a_frag_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_crc == CRC_INIT) && (r_cnt == '0))
        else $error("state not cleared after last byte");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_avail && i_item.last && i_res_full) |-> !o_take)
        else $error("last byte taken with result queue full");

endmodule

`default_nettype wire

FILE: design/reloc_masked_crc_signature_match.sv
// Relocation-masked CRC-32 signature matcher. Bytes of a code fragment enter
// one per request in order, each tagged with the relocation kind of its word;
// relocated fields are masked by byte lane (words aligned to the fragment
// start) and fed to a reflected CRC-32. The request marked last_byte yields
// one result: the full CRC, whether the CRC of the first HEAD_BYTES bytes (or
// of the whole fragment, if shorter) matches the expected head CRC, and
// whether both match. Other requests yield nothing. One byte is taken every
// cycle, unless a last byte meets a full output queue; that rate is set by
// the combinational eight-bit CRC update in the back end. A result reaches
// the output queue via the mid queue and back end. The user must write
// expected CRCs only while no fragment is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module reloc_masked_crc_signature_match #(
    parameter int HEAD_BYTES = rmcrc_pkg::HEAD_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [7:0]                     i_code_byte,
    input  wire logic [1:0]                     i_reloc_kind,
    input  wire logic                           i_last_byte,
    output logic                                empty,
    input  wire logic                           pop,
    output logic                                o_head_match,
    output logic                                o_signature_match,
    output logic [31:0]                         o_full_crc,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rmcrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    import rmcrc_pkg::*;

    logic        w_in_accept;
    t_mid_item   w_front_item;
    t_mid_item   w_mid_item;
    logic        w_mid_full, w_mid_empty, w_mid_take;
    t_res_item   w_res_in, w_res_out;
    logic        w_res_full, w_res_push;
    logic [31:0] r_exp_head, r_exp_full;

    assign w_in_accept = push && !w_mid_full;
    assign full        = w_mid_full;
    assign o_cfg_ready = 1'b1;

    rmcrc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_code_byte  (i_code_byte),
        .i_reloc_kind (i_reloc_kind),
        .i_last_byte  (i_last_byte),
        .o_item       (w_front_item)
    );

    rmcrc_queue #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_in_accept),
        .i_wdata (w_front_item),
        .o_full  (w_mid_full),
        .i_rd    (w_mid_take),
        .o_rdata (w_mid_item),
        .o_empty (w_mid_empty)
    );

    rmcrc_back #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (!w_mid_empty),
        .i_item     (w_mid_item),
        .o_take     (w_mid_take),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res_in)
    );

    rmcrc_queue #(
        .WIDTH ($bits(t_res_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_rdata (w_res_out),
        .o_empty (empty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_head <= '0;
            r_exp_full <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_HEAD_CRC: r_exp_head <= i_cfg_data;
                CFG_FULL_CRC: r_exp_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_full_crc        = w_res_out.full_crc;
    assign o_head_match      = (w_res_out.head_crc == r_exp_head);
    assign o_signature_match = o_head_match && (w_res_out.full_crc == r_exp_full);

endmodule

`default_nettype wire

FILE: dv/reloc_masked_crc_signature_match_test.sv
`timescale 1ns / 1ps

module reloc_masked_crc_signature_match_test;
    import rmcrc_pkg::*;

    localparam int          HEAD_LEN      = HEAD_BYTES_DEF;
    localparam int          ITEM_TARGET   = 1150;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          QUIET_LIMIT   = 2000;
    localparam logic [1:0]  RELOC_SPARE   = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
    } t_code_byte;

    typedef struct {
        logic        head_match;
        logic        sig_match;
        logic [31:0] crc;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        push         = 1'b0;
    logic        full;
    logic [7:0]  i_code_byte  = 8'h00;
    logic [1:0]  i_reloc_kind = RELOC_NONE;
    logic        i_last_byte  = 1'b0;
    logic        empty;
    logic        pop          = 1'b0;
    logic        o_head_match;
    logic        o_signature_match;
    logic [31:0] o_full_crc;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    t_cfg_reg    i_cfg_index  = CFG_HEAD_CRC;
    logic [31:0] i_cfg_data   = 32'h0;

    reloc_masked_crc_signature_match #(
        .HEAD_BYTES(HEAD_LEN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_code_byte      (i_code_byte),
        .i_reloc_kind     (i_reloc_kind),
        .i_last_byte      (i_last_byte),
        .empty            (empty),
        .pop              (pop),
        .o_head_match     (o_head_match),
        .o_signature_match(o_signature_match),
        .o_full_crc       (o_full_crc),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // signature predictor state
    logic [31:0] want_head = 32'h0;
    logic [31:0] want_full = 32'h0;
    logic [31:0] crc_acc   = CRC_INIT;
    logic [31:0] head_sig  = 32'h0;
    int          head_cnt  = 0;
    logic [1:0]  lane      = 2'd0;
    t_verdict    verdict_q[$];
    t_verdict    due;

    t_code_byte  frag[$];
    t_code_byte  golden[$];

    bit          calm = 1'b0;
    int          errors;
    int          quiet;
    int          bytes_sent;
    int          n_frags;
    int          n_results;
    int          n_head_hits;
    int          n_sig_hits;
    int          n_cfg_writes;
    int          n_pauses;
    int          phases;
    int          kind_seen[4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_error(input string what);
        if (errors < 10) begin
            $display("error: %s", what);
        end
        errors++;
    endfunction

    function automatic logic [7:0] lane_mask(input logic [7:0] b, input logic [1:0] k,
                                             input logic [1:0] ln);
        case (k)
            RELOC_TARGET26: return (ln == 2'd0) ? (b & TARGET_MASK) : 8'h00;
            RELOC_HILO16:   return ln[1] ? 8'h00 : b;
            default:        return b;
        endcase
    endfunction

    // reflected crc-32, one data bit folded in per shift
    function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = {1'b0, r[31:1]} ^ ((r[0] ^ b[i]) ? CRC_POLY : 32'h0);
        end
        return r;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic [1:0] k,
                                         input logic l);
        t_verdict    v;
        logic [31:0] whole;
        logic [31:0] head;
        crc_acc = crc8(crc_acc, lane_mask(b, k, lane));
        lane    = lane + 2'd1;
        if (head_cnt < HEAD_LEN) begin
            head_cnt++;
            if (head_cnt == HEAD_LEN) begin
                head_sig = ~crc_acc;
            end
        end
        if (l) begin
            whole        = ~crc_acc;
            head         = (head_cnt >= HEAD_LEN) ? head_sig : whole;
            v.head_match = (head == want_head);
            v.sig_match  = v.head_match && (whole == want_full);
            v.crc        = whole;
            verdict_q.insert(verdict_q.size(), v);
            n_head_hits += v.head_match;
            n_sig_hits  += v.sig_match;
            crc_acc  = CRC_INIT;
            head_sig = 32'h0;
            head_cnt = 0;
            lane     = 2'd0;
        end
    endfunction

    // head and full signatures of the fragment being built
    function automatic void fragment_signature(output logic [31:0] head,
                                               output logic [31:0] whole);
        logic [31:0] c;
        c    = CRC_INIT;
        head = 32'h0;
        foreach (frag[i]) begin
            c = crc8(c, lane_mask(frag[i].data, frag[i].kind, 2'(i)));
            if (i == HEAD_LEN - 1) begin
                head = ~c;
            end
        end
        whole = ~c;
        if (frag.size() < HEAD_LEN) begin
            head = whole;
        end
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic [1:0] k);
        frag.insert(frag.size(), t_code_byte'{data: b, kind: k});
    endfunction

    function automatic void add_word(input logic [31:0] w, input logic [1:0] k);
        for (int j = 3; j >= 0; j--) begin
            add_byte(w[8*j +: 8], k);
        end
    endfunction

    function automatic void random_fragment(input int unsigned len, input bit per_byte_kinds);
        logic [1:0] k;
        k = RELOC_NONE;
        frag.delete();
        for (int unsigned i = 0; i < len; i++) begin
            if (per_byte_kinds || (i % 4 == 0)) begin
                k = 2'($urandom_range(3));
            end
            add_byte(8'($urandom), k);
        end
    endfunction

    function automatic int unsigned random_length();
        return ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 48);
    endfunction

    // request side
    task automatic push_byte(input logic [7:0] b, input logic [1:0] k, input logic l);
        while (!calm && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_code_byte  <= b;
        i_reloc_kind <= k;
        i_last_byte  <= l;
        do @(posedge i_clk); while (full);
        predict_byte(b, k, l);
        bytes_sent++;
        kind_seen[k]++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_fragment();
        int unsigned hold_at;
        hold_at = ($urandom_range(19) == 0) ? $urandom_range(frag.size() - 1) : 0;
        n_frags++;
        foreach (frag[i]) begin
            if (i != 0 && i == hold_at) begin
                n_pauses++;
                wait_for_results();
            end
            push_byte(frag[i].data, frag[i].kind, i == frag.size() - 1);
        end
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HEAD_CRC) begin
            want_head = val;
        end else begin
            want_full = val;
        end
        n_cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] head, input logic [31:0] whole);
        write_reg(CFG_HEAD_CRC, head);
        write_reg(CFG_FULL_CRC, whole);
        i_cfg_valid <= 1'b0;
    endtask

    // single-byte fragments against the reset register values
    task automatic test_short_fragments();
        push_byte(8'h00, RELOC_NONE, 1'b1);
        push_byte(8'hFF, RELOC_SPARE, 1'b1);
        push_byte(8'hFF, RELOC_TARGET26, 1'b1);
        settle();
    endtask

    // every relocation kind across all lanes, head cut at eight bytes
    task automatic test_masking_and_signature();
        logic [31:0] h;
        logic [31:0] f;
        frag.delete();
        add_word(32'hFFFF_FFFF, RELOC_TARGET26);
        add_word(32'hFFFF_FFFF, RELOC_HILO16);
        add_word(32'h0080_7FFF, RELOC_NONE);
        fragment_signature(h, f);
        program_regs(h, f);
        send_fragment();
        // different head and tail, same expected registers
        frag.delete();
        add_word(32'h1234_5678, RELOC_TARGET26);
        add_word(32'h9ABC_DEF0, RELOC_HILO16);
        add_byte(8'h5A, RELOC_NONE);
        send_fragment();
        settle();
    endtask

    // one register rewritten while the other holds
    task automatic test_register_update();
        logic [31:0] h;
        logic [31:0] f;
        frag.delete();
        add_byte(8'hA5, RELOC_HILO16);
        add_byte(8'h3C, RELOC_HILO16);
        fragment_signature(h, f);
        write_reg(CFG_HEAD_CRC, h);
        i_cfg_valid <= 1'b0;
        send_fragment();
        settle();
        write_reg(CFG_FULL_CRC, f);
        i_cfg_valid <= 1'b0;
        send_fragment();
        settle();
    endtask

    task automatic test_random_signatures();
        int unsigned mode;
        int unsigned n_run;
        int unsigned v;
        int unsigned pos;
        int unsigned w;
        logic [1:0]  newk;
        logic [31:0] h;
        logic [31:0] f;
        while (bytes_sent < ITEM_TARGET) begin
            phases++;
            calm = (phases == 3);
            random_fragment(random_length(), 1'b0);
            golden = frag;
            fragment_signature(h, f);
            mode = (phases <= 2) ? phases - 1 : $urandom_range(6);
            case (mode)
                0:       program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1:       program_regs(32'h0, 32'h0);
                2:       program_regs(h, $urandom);
                3:       program_regs($urandom, $urandom);
                default: program_regs(h, f);
            endcase
            n_run = calm ? 40 : $urandom_range(6, 16);
            repeat (n_run) begin
                v = $urandom_range(99);
                if (v < 40) begin
                    frag = golden;
                end else if (v < 65) begin
                    frag = golden;
                    pos  = $urandom_range(frag.size() - 1);
                    frag[pos].data = frag[pos].data ^ 8'(1 << $urandom_range(7));
                end else if (v < 75) begin
                    frag = golden;
                    w    = 4 * $urandom_range((frag.size() - 1) / 4);
                    newk = 2'($urandom_range(3));
                    for (int j = w; j < w + 4 && j < frag.size(); j++) begin
                        frag[j].kind = newk;
                    end
                end else if (v < 90) begin
                    random_fragment(random_length(), 1'b0);
                end else begin
                    random_fragment($urandom_range(1, 12), 1'b1);
                end
                send_fragment();
            end
            settle();
            calm = 1'b0;
        end
    endtask

    // response side
    always @(negedge i_clk) begin
        pop <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            n_results++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("result with nothing pending, full_crc %08h", o_full_crc));
            end else begin
                due = verdict_q.pop_front();
                if (o_head_match !== due.head_match || o_signature_match !== due.sig_match
                        || o_full_crc !== due.crc) begin
                    flag_error($sformatf({"result %0d: head_match %0b/%0b ",
                        "signature_match %0b/%0b full_crc %08h/%08h (expected/actual)"},
                        n_results, due.head_match, o_head_match, due.sig_match,
                        o_signature_match, due.crc, o_full_crc));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("reloc_masked_crc_signature_match_test NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_fragments();
        test_masking_and_signature();
        test_register_update();
        test_random_signatures();
        settle();
        if (verdict_q.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", verdict_q.size()));
        end
        $display("covered %0d bytes in %0d fragments, %0d register writes, %0d mid-stream drains",
                 bytes_sent, n_frags, n_cfg_writes, n_pauses);
        $display("head matches %0d, full matches %0d; kinds none/jump/hilo/spare %0d/%0d/%0d/%0d",
                 n_head_hits, n_sig_hits, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3]);
        if (errors == 0) begin
            $display("reloc_masked_crc_signature_match_test OK");
        end else begin
            $display("reloc_masked_crc_signature_match_test NOT OK");
        end
        $finish;
    end

endmodule

FILE: reloc_masked_crc_signature_match.f
design/rmcrc_pkg.sv
design/rmcrc_queue.sv
design/rmcrc_front.sv
design/rmcrc_back.sv
design/reloc_masked_crc_signature_match.sv
dv/reloc_masked_crc_signature_match_test.sv
